// ===== src/rmt_pkg.sv =====
// shared types and constants for the range mex min-tree
`timescale 1ns / 1ps

package rmt_pkg;

    localparam int VALUE_W  = 10;
    localparam int POS_IN_W = 16;
    localparam int MEX_W    = 10;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_UP    = 4'b0100,
        S_DOWN  = 4'b1000
    } t_state;

    typedef struct packed {
        logic clr;
        logic rec_start;
        logic up;
        logic qry_start;
        logic down;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic rec_ok;
        logic up_last;
        logic down_last;
    } t_sts;

endpackage

// ===== src/range_mex_min_tree.sv =====
// top level of the range mex min-tree: controller, datapath and checks
// record: busy while the climb runs, one memory write per level from the leaf up to the root
// query: descends from the root one level per step; the result strobe is registered from the last step
// a new request is taken in the cycle the result strobe is shown; no request is taken while busy
// after reset all 2 * slots tree memory entries are zeroed one entry a cycle, busy high
// results are shown for one cycle only, the receiver cannot stall
`timescale 1ns / 1ps

module range_mex_min_tree #(
    parameter int LEAVES    = 1024,
    parameter int POS_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_kind,
    input  logic [rmt_pkg::VALUE_W-1:0]  i_value,
    input  logic [rmt_pkg::POS_IN_W-1:0] i_position,
    input  logic [rmt_pkg::POS_IN_W-1:0] i_left_bound,
    output logic                         o_mex_valid,
    output logic [rmt_pkg::MEX_W-1:0]    o_mex
);

    import rmt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    rmt_dp #(
        .LEAVES    (LEAVES),
        .POS_WIDTH (POS_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_value      (i_value),
        .i_position   (i_position),
        .i_left_bound (i_left_bound),
        .o_sts        (w_sts),
        .o_mex_valid  (o_mex_valid),
        .o_mex        (o_mex)
    );

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_QUERY) |=> busy)
        else $error("query request did not hold busy");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mex_valid |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mex_valid |=> !o_mex_valid)
        else $error("result strobe longer than one cycle");

endmodule

// ===== src/rmt_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module rmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rmt_ctrl.sv =====
// controller state machine for clear, record climb and query descent
`timescale 1ns / 1ps

module rmt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_kind,
    input  rmt_pkg::t_sts i_sts,
    output rmt_pkg::t_cmd o_cmd,
    output logic          busy
);

    import rmt_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_kind == KIND_QUERY) begin
                        w_cmd.qry_start = 1'b1;
                        n_state = S_DOWN;
                    end else if (i_sts.rec_ok) begin
                        w_cmd.rec_start = 1'b1;
                        n_state = S_UP;
                    end
                end
            end
            S_UP: begin
                w_cmd.up = 1'b1;
                if (i_sts.up_last) begin
                    n_state = S_IDLE;
                end
            end
            S_DOWN: begin
                w_cmd.down = 1'b1;
                if (i_sts.down_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_cmd = w_cmd;
    assign busy  = (r_state != S_IDLE);

endmodule

// ===== src/rmt_dp.sv =====
// datapath: node pointer, running minimum, tree memory and result register
`timescale 1ns / 1ps

module rmt_dp #(
    parameter int LEAVES    = 1024,
    parameter int POS_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rmt_pkg::t_cmd                i_cmd,
    input  logic [rmt_pkg::VALUE_W-1:0]  i_value,
    input  logic [rmt_pkg::POS_IN_W-1:0] i_position,
    input  logic [rmt_pkg::POS_IN_W-1:0] i_left_bound,
    output rmt_pkg::t_sts                o_sts,
    output logic                         o_mex_valid,
    output logic [rmt_pkg::MEX_W-1:0]    o_mex
);

    import rmt_pkg::*;

    localparam int LEVELS = $clog2(LEAVES);
    localparam int SLOTS  = 1 << LEVELS;
    localparam int NW     = LEVELS + 1;
    localparam int DEPTH  = 2 * SLOTS;

    logic [NW-1:0]        r_node;
    logic [POS_WIDTH-1:0] r_cur;
    logic [POS_WIDTH-1:0] r_bound;
    logic [NW-1:0]        r_clr;
    logic [MEX_W-1:0]     r_mex;
    logic                 r_done;

    logic                 w_we;
    logic [NW-1:0]        w_waddr;
    logic [POS_WIDTH-1:0] w_wdata;
    logic [NW-1:0]        w_raddr;
    logic [POS_WIDTH-1:0] w_rdata;

    logic [POS_WIDTH-1:0] w_pos;
    logic [POS_WIDTH-1:0] w_bound;
    logic [NW-1:0]        w_leaf;
    logic [NW-1:0]        w_par;
    logic [POS_WIDTH-1:0] w_min;
    logic [NW-1:0]        w_left;
    logic [NW-1:0]        w_next;
    t_sts                 w_sts;

    assign w_pos   = POS_WIDTH'(i_position);
    assign w_bound = POS_WIDTH'(i_left_bound);
    assign w_leaf  = NW'(SLOTS) | NW'(i_value);
    assign w_par   = r_node >> 1;
    assign w_min   = (w_rdata < r_cur) ? w_rdata : r_cur;
    assign w_left  = r_node << 1;
    assign w_next  = (w_rdata < r_bound) ? w_left : (w_left | NW'(1));

    always_comb begin
        w_sts.clr_last  = (r_clr == NW'(DEPTH - 1));
        w_sts.rec_ok    = (32'(i_value) < SLOTS);
        w_sts.up_last   = (w_par == NW'(1));
        w_sts.down_last = w_next[NW-1];
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_par;
        w_wdata = w_min;
        w_raddr = w_next << 1;
        if (i_cmd.clr) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (i_cmd.rec_start) begin
            w_we    = 1'b1;
            w_waddr = w_leaf;
            w_wdata = w_pos;
            w_raddr = w_leaf ^ NW'(1);
        end else if (i_cmd.up) begin
            w_we    = 1'b1;
            w_raddr = w_par ^ NW'(1);
        end else if (i_cmd.qry_start) begin
            w_raddr = NW'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + NW'(1);
            end
            r_done <= i_cmd.down & w_sts.down_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rec_start) begin
            r_node <= w_leaf;
            r_cur  <= w_pos;
        end else if (i_cmd.up) begin
            r_node <= w_par;
            r_cur  <= w_min;
        end else if (i_cmd.qry_start) begin
            r_node  <= NW'(1);
            r_bound <= w_bound;
        end else if (i_cmd.down) begin
            r_node <= w_next;
        end
        if (i_cmd.down && w_sts.down_last) begin
            r_mex <= MEX_W'(w_next[LEVELS-1:0]);
        end
    end

    rmt_ram #(
        .WIDTH (POS_WIDTH),
        .DEPTH (DEPTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_sts       = w_sts;
    assign o_mex_valid = r_done;
    assign o_mex       = r_mex;

endmodule

// ===== sim/range_mex_min_tree_test.sv =====
// self-checking test of the range mex min-tree: min-tree predictor, directed and random requests
`timescale 1ns / 1ps

module range_mex_min_tree_test;
    import rmt_pkg::*;

    localparam int SLOTS          = 1024;
    localparam int END_WAIT       = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_kind;
    logic [VALUE_W-1:0]  i_value;
    logic [POS_IN_W-1:0] i_position;
    logic [POS_IN_W-1:0] i_left_bound;
    logic                o_mex_valid;
    logic [MEX_W-1:0]    o_mex;

    logic [POS_IN_W-1:0] last_seen_tree [1:2*SLOTS-1];
    logic [MEX_W-1:0]    mex_expect_q [$];
    int                  error_count = 0;
    int                  sent_count  = 0;
    int                  idle_cycles = 0;
    int unsigned         cursor      = 1;
    bit                  gaps_on     = 1'b1;

    range_mex_min_tree uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .i_position   (i_position),
        .i_left_bound (i_left_bound),
        .o_mex_valid  (o_mex_valid),
        .o_mex        (o_mex)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void store_last_seen(input logic [VALUE_W-1:0] value,
                                            input logic [POS_IN_W-1:0] pos);
        int node;
        node = SLOTS + int'(value);
        last_seen_tree[node] = pos;
        for (node = node >> 1; node > 0; node = node >> 1) begin
            last_seen_tree[node] = (last_seen_tree[2*node] < last_seen_tree[2*node+1]) ?
                                   last_seen_tree[2*node] : last_seen_tree[2*node+1];
        end
    endfunction

    function automatic logic [MEX_W-1:0] descend_mex(input logic [POS_IN_W-1:0] bound);
        int node;
        node = 1;
        while (node < SLOTS) begin
            node = (last_seen_tree[2*node] < bound) ? 2*node : 2*node + 1;
        end
        return MEX_W'(node - SLOTS);
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 14);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [MEX_W-1:0] expected,
                                   input logic [MEX_W-1:0] got);
        $display("mismatch: %s, expected %0d, got %0d, at %0t", what, expected, got, $realtime);
        error_count++;
    endtask

    task automatic send_request(input logic kind, input logic [VALUE_W-1:0] value,
                                input logic [POS_IN_W-1:0] pos,
                                input logic [POS_IN_W-1:0] bound);
        int gap;
        start        <= 1'b1;
        i_kind       <= kind;
        i_value      <= value;
        i_position   <= pos;
        i_left_bound <= bound;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (kind == KIND_RECORD) begin
            store_last_seen(value, pos);
        end else begin
            mex_expect_q.insert(mex_expect_q.size(), descend_mex(bound));
        end
        sent_count++;
        gap = gaps_on ? random_gap() : 0;
        if (gap > 0) begin
            start        <= 1'b0;
            i_kind       <= 1'($urandom);
            i_value      <= VALUE_W'($urandom);
            i_position   <= POS_IN_W'($urandom);
            i_left_bound <= POS_IN_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // records at rising positions from a fresh base, queries bounded from just below the base up to the cursor
    task automatic run_segment(input int count);
        int base;
        int alphabet;
        int i;
        cursor   = cursor + $urandom_range(1, 300);
        base     = cursor;
        alphabet = $urandom_range(1, 40);
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 35) begin
                send_request(KIND_QUERY, VALUE_W'($urandom), POS_IN_W'($urandom),
                             POS_IN_W'($urandom_range(base > 3 ? base - 3 : 0, cursor)));
            end else begin
                send_request(KIND_RECORD, VALUE_W'($urandom_range(0, alphabet - 1)),
                             POS_IN_W'(cursor), POS_IN_W'($urandom));
                cursor++;
            end
        end
    endtask

    task automatic test_directed();
        send_request(KIND_QUERY,  10'd0,    16'd0,      16'd0);
        send_request(KIND_QUERY,  10'h3FF,  16'hFFFF,   16'd1);
        send_request(KIND_QUERY,  10'd0,    16'd0,      16'hFFFF);
        send_request(KIND_QUERY,  10'd0,    16'd0,      16'h8000);
        send_request(KIND_RECORD, 10'd0,    16'd1,      16'hFFFF);
        send_request(KIND_QUERY,  10'd0,    16'd0,      16'd1);
        send_request(KIND_QUERY,  10'd0,    16'd0,      16'd2);
        send_request(KIND_RECORD, 10'd1,    16'd2,      16'd0);
        send_request(KIND_RECORD, 10'd2,    16'd3,      16'd0);
        send_request(KIND_QUERY,  10'd0,    16'd0,      16'd1);
        send_request(KIND_QUERY,  10'd0,    16'd0,      16'd3);
        send_request(KIND_RECORD, 10'h3FF,  16'hFFFF,   16'd0);
        send_request(KIND_RECORD, 10'h200,  16'h5555,   16'd0);
        send_request(KIND_RECORD, 10'h155,  16'hAAAA,   16'd0);
        send_request(KIND_RECORD, 10'h2AA,  16'h0000,   16'd0);
        send_request(KIND_QUERY,  10'd0,    16'd0,      16'hFFFF);
        send_request(KIND_QUERY,  10'd0,    16'd0,      16'hAAAB);
        send_request(KIND_QUERY,  10'd0,    16'd0,      16'd0);
        send_request(KIND_RECORD, 10'd0,    16'd0,      16'd0);
        send_request(KIND_QUERY,  10'd0,    16'd0,      16'd1);
        send_request(KIND_QUERY,  10'h3FF,  16'hFFFF,   16'h0001);
    endtask

    task automatic test_segments();
        while (sent_count < 320) run_segment($urandom_range(3, 24));
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        run_segment(20);
        run_segment(20);
        gaps_on = 1'b1;
    endtask

    task automatic test_noise();
        int i;
        for (i = 0; i < 60; i++) begin
            send_request(1'($urandom), VALUE_W'($urandom), POS_IN_W'($urandom),
                         POS_IN_W'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_mex_valid) begin
            if (mex_expect_q.size() == 0) begin
                report_mismatch("result with no query waiting", '0, o_mex);
            end else if (o_mex !== mex_expect_q[0]) begin
                report_mismatch("mex", mex_expect_q.pop_front(), o_mex);
            end else begin
                void'(mex_expect_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy && i_rst_n) || o_mex_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("range_mex_min_tree_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (last_seen_tree[n]) last_seen_tree[n] = '0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_kind       <= KIND_RECORD;
        i_value      <= '0;
        i_position   <= '0;
        i_left_bound <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_segments();
        test_back_to_back();
        test_noise();

        start <= 1'b0;
        while (mex_expect_q.size() != 0) @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("range_mex_min_tree_test: done, clean");
        end else begin
            $display("range_mex_min_tree_test: done, errors");
        end
        $finish;
    end

endmodule
